// File: sv/srarb_pkg.sv
package srarb_pkg;

    localparam int OWNER_BITS   = 4;
    localparam int CONTEXT_BITS = 8;
    localparam int DEPTH_BITS   = 16;
    localparam int TIME_BITS    = 64;
    localparam int COUNT_BITS   = 32;

    typedef enum logic [1:0] {
        OP_RESERVE    = 2'd0,
        OP_RELEASE    = 2'd1,
        OP_ACQUIRE_IO = 2'd2,
        OP_RELEASE_IO = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     opcode;
        logic [OWNER_BITS-1:0]   owner;
        logic                    access;
        logic [CONTEXT_BITS-1:0] context_req;
        logic [TIME_BITS-1:0]    now_us;
        logic [TIME_BITS-1:0]    start_us;
    } req_t;

    typedef struct packed {
        logic                    granted;
        logic [OWNER_BITS-1:0]   mutation_owner;
        logic                    mutation_active;
        logic [OWNER_BITS-1:0]   read_owner;
        logic [COUNT_BITS-1:0]   rejected_count;
        logic [COUNT_BITS-1:0]   reservation_count;
        logic [COUNT_BITS-1:0]   io_acquire_count;
        logic [COUNT_BITS-1:0]   max_wait_us;
        logic [COUNT_BITS-1:0]   max_hold_us;
    } rsp_t;

    function automatic logic [COUNT_BITS-1:0] sat_elapsed(
        input logic [TIME_BITS-1:0] now_us,
        input logic [TIME_BITS-1:0] start_us
    );
        logic [TIME_BITS-1:0] diff;
        begin
            diff = now_us - start_us;
            if (|diff[TIME_BITS-1:COUNT_BITS])
                sat_elapsed = {COUNT_BITS{1'b1}};
            else
                sat_elapsed = diff[COUNT_BITS-1:0];
        end
    endfunction

endpackage

// File: sv/storage_reservation_arbiter_core.sv
// Reentrant storage reservation arbiter. One request per cycle is accepted
// while the response side is not stalled, and each request yields exactly one
// response: it passes through the request register, where the grant check,
// the owner/depth update and the 64-bit elapsed-time subtraction are done, and
// then through the response register. Back-to-back requests see the state left
// by the previous one with no bubble. Response fields report owners and
// counters after the request has taken effect.
module storage_reservation_arbiter_core #(
    parameter int DEPTH_BITS = srarb_pkg::DEPTH_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  srarb_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output srarb_pkg::rsp_t   rsp
);

    logic            hold_valid;
    srarb_pkg::req_t hold_req;
    logic            load_ready;
    logic            advance;
    srarb_pkg::rsp_t engine_rsp;

    assign advance = hold_valid && load_ready;

    srarb_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_req   (hold_req)
    );

    srarb_engine #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (hold_req),
        .rsp   (engine_rsp)
    );

    srarb_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid),
        .load_ready (load_ready),
        .load_rsp   (engine_rsp),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

// File: sv/srarb_in_reg.sv
module srarb_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  srarb_pkg::req_t   req,
    input  logic              advance,
    output logic              hold_valid,
    output srarb_pkg::req_t   hold_req
);

    logic            valid_reg;
    logic            valid_next;
    srarb_pkg::req_t req_reg;

    assign req_ready  = !valid_reg || advance;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
    end

    assign hold_valid = valid_reg;
    assign hold_req   = req_reg;

endmodule

// File: sv/srarb_engine.sv
module srarb_engine #(
    parameter int DEPTH_BITS = srarb_pkg::DEPTH_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  srarb_pkg::req_t   req,
    output srarb_pkg::rsp_t   rsp
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    logic [srarb_pkg::OWNER_BITS-1:0]   mut_owner_reg, mut_owner_next;
    logic [srarb_pkg::CONTEXT_BITS-1:0] mut_context_reg, mut_context_next;
    logic [DEPTH_BITS-1:0]              mut_depth_reg, mut_depth_next;
    logic [srarb_pkg::OWNER_BITS-1:0]   rd_owner_reg, rd_owner_next;
    logic [srarb_pkg::CONTEXT_BITS-1:0] rd_context_reg, rd_context_next;
    logic [DEPTH_BITS-1:0]              rd_depth_reg, rd_depth_next;
    logic [srarb_pkg::COUNT_BITS-1:0]   reject_reg, reject_next;
    logic [srarb_pkg::COUNT_BITS-1:0]   reserve_reg, reserve_next;
    logic [srarb_pkg::COUNT_BITS-1:0]   io_reg, io_next;
    logic [srarb_pkg::COUNT_BITS-1:0]   wait_peak_reg, wait_peak_next;
    logic [srarb_pkg::COUNT_BITS-1:0]   hold_peak_reg, hold_peak_next;

    logic [srarb_pkg::COUNT_BITS-1:0] elapsed;
    logic mut_match, rd_match, mut_free, rd_free, ok, granted;

    assign elapsed   = srarb_pkg::sat_elapsed(req.now_us, req.start_us);
    assign mut_match = (mut_owner_reg == req.owner) && (mut_context_reg == req.context_req);
    assign rd_match  = (rd_owner_reg == req.owner) && (rd_context_reg == req.context_req);
    assign mut_free  = (mut_owner_reg == '0) || mut_match;
    assign rd_free   = (rd_owner_reg == '0) || rd_match;

    always_comb
    begin
        if (req.owner == '0)
            ok = 1'b0;
        else if (req.access || (req.opcode == srarb_pkg::OP_RESERVE))
            ok = mut_free && rd_free;
        else
            ok = mut_free;
    end

    always_comb
    begin
        mut_owner_next   = mut_owner_reg;
        mut_context_next = mut_context_reg;
        mut_depth_next   = mut_depth_reg;
        rd_owner_next    = rd_owner_reg;
        rd_context_next  = rd_context_reg;
        rd_depth_next    = rd_depth_reg;
        reject_next      = reject_reg;
        reserve_next     = reserve_reg;
        io_next          = io_reg;
        wait_peak_next   = wait_peak_reg;
        hold_peak_next   = hold_peak_reg;
        granted          = 1'b1;
        case (req.opcode)
            srarb_pkg::OP_RESERVE,
            srarb_pkg::OP_ACQUIRE_IO:
            begin
                if (elapsed > wait_peak_reg)
                    wait_peak_next = elapsed;
                if (!ok)
                begin
                    reject_next = reject_reg + 1'b1;
                    granted     = 1'b0;
                end
                else if (req.opcode == srarb_pkg::OP_RESERVE)
                begin
                    reserve_next = reserve_reg + 1'b1;
                    if (req.access)
                    begin
                        mut_owner_next   = req.owner;
                        mut_context_next = req.context_req;
                        if (mut_depth_reg != DEPTH_MAX)
                            mut_depth_next = mut_depth_reg + 1'b1;
                    end
                    else
                    begin
                        rd_owner_next   = req.owner;
                        rd_context_next = req.context_req;
                        if (rd_depth_reg != DEPTH_MAX)
                            rd_depth_next = rd_depth_reg + 1'b1;
                    end
                end
                else
                    io_next = io_reg + 1'b1;
            end
            srarb_pkg::OP_RELEASE:
            begin
                if (req.access)
                begin
                    if (mut_match && (mut_depth_reg != '0))
                    begin
                        mut_depth_next = mut_depth_reg - 1'b1;
                        if (mut_depth_reg == DEPTH_ONE)
                        begin
                            mut_owner_next   = '0;
                            mut_context_next = '0;
                        end
                    end
                end
                else if (rd_match && (rd_depth_reg != '0))
                begin
                    rd_depth_next = rd_depth_reg - 1'b1;
                    if (rd_depth_reg == DEPTH_ONE)
                    begin
                        rd_owner_next   = '0;
                        rd_context_next = '0;
                    end
                end
            end
            default:
            begin
                if (elapsed > hold_peak_reg)
                    hold_peak_next = elapsed;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mut_owner_reg   <= '0;
            mut_context_reg <= '0;
            mut_depth_reg   <= '0;
            rd_owner_reg    <= '0;
            rd_context_reg  <= '0;
            rd_depth_reg    <= '0;
            reject_reg      <= '0;
            reserve_reg     <= '0;
            io_reg          <= '0;
            wait_peak_reg   <= '0;
            hold_peak_reg   <= '0;
        end
        else if (fire)
        begin
            mut_owner_reg   <= mut_owner_next;
            mut_context_reg <= mut_context_next;
            mut_depth_reg   <= mut_depth_next;
            rd_owner_reg    <= rd_owner_next;
            rd_context_reg  <= rd_context_next;
            rd_depth_reg    <= rd_depth_next;
            reject_reg      <= reject_next;
            reserve_reg     <= reserve_next;
            io_reg          <= io_next;
            wait_peak_reg   <= wait_peak_next;
            hold_peak_reg   <= hold_peak_next;
        end
    end

    always_comb
    begin
        rsp.granted           = granted;
        rsp.mutation_owner    = mut_owner_next;
        rsp.mutation_active   = (mut_owner_next != '0);
        rsp.read_owner        = rd_owner_next;
        rsp.rejected_count    = reject_next;
        rsp.reservation_count = reserve_next;
        rsp.io_acquire_count  = io_next;
        rsp.max_wait_us       = wait_peak_next;
        rsp.max_hold_us       = hold_peak_next;
    end

endmodule

// File: sv/srarb_out_reg.sv
module srarb_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  srarb_pkg::rsp_t   load_rsp,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output srarb_pkg::rsp_t   rsp
);

    logic            valid_reg;
    logic            valid_next;
    srarb_pkg::rsp_t rsp_reg;

    assign load_ready = !valid_reg || rsp_ready;
    assign valid_next = load_ready ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
            rsp_reg <= load_rsp;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule
